FILE: design/string_render_parser_defines.svh
// Assertion macros shared by the string render parser RTL.
// No dependencies; included by the files that carry assertions.
`ifndef STRING_RENDER_PARSER_DEFINES_SVH
`define STRING_RENDER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("string_render_parser assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("string_render_parser assertion failed");

`endif

FILE: design/srp_pkg.sv
// Types, constants and helper functions of the string render parser.
// No dependencies; imported by every module of the block.
package srp_pkg;

	localparam int POS_WIDTH = 16;
	localparam int CMD_DEPTH = 2;  // power of two
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	// result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_BADCH  = 2'd1;
	localparam logic [1:0] KIND_ACCEPT = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_QUOTE    = 2'd0;
	localparam logic [1:0] REG_BIG_END  = 2'd1;
	localparam logic [1:0] REG_BOM      = 2'd2;
	localparam logic [1:0] REG_CHARSET  = 2'd3;

	// charset codes (also the override register encoding)
	localparam logic [1:0] CS_PREFIX = 2'd0;
	localparam logic [1:0] CS_ONE    = 2'd1;
	localparam logic [1:0] CS_TWO    = 2'd2;
	localparam logic [1:0] CS_FOUR   = 2'd3;

	// characters
	localparam logic [7:0] CH_LOW_U   = 8'h75;
	localparam logic [7:0] CH_UP_U    = 8'h55;
	localparam logic [7:0] CH_EIGHT   = 8'h38;
	localparam logic [7:0] CH_APOS    = 8'h27;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_LOW_H   = 8'h68;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_B   = 8'h62;
	localparam logic [7:0] CH_LOW_T   = 8'h74;
	localparam logic [7:0] CH_LOW_N   = 8'h6E;
	localparam logic [7:0] CH_LOW_V   = 8'h76;
	localparam logic [7:0] CH_LOW_F   = 8'h66;
	localparam logic [7:0] CH_LOW_R   = 8'h72;
	localparam logic [7:0] CH_LOW_X   = 8'h78;

	localparam logic [7:0] BOM_HI = 8'hFE;
	localparam logic [7:0] BOM_LO = 8'hFF;
	localparam logic [7:0] SURR_OFS = 8'h40;  // 0x10000 >> 10

	typedef enum logic [3:0] {
		ST_INIT   = 4'd0,
		ST_PREFIX = 4'd1,
		ST_UNIT   = 4'd2,
		ST_STR    = 4'd3,
		ST_BYTE   = 4'd4,
		ST_SUFFIX = 4'd5,
		ST_COMMA  = 4'd6,
		ST_ESCAPE = 4'd7,
		ST_CODE   = 4'd8
	} srp_state_t;

	typedef struct packed {
		logic       action;
		logic [7:0] char_code;
	} srp_in_t;

	typedef struct packed {
		logic [7:0]           out_byte;
		logic [1:0]           kind;
		logic [POS_WIDTH-1:0] position;
		logic                 last;
	} srp_out_t;

	// work handed from the parser to the emitter: one to four results
	typedef struct packed {
		logic [1:0]           kind;
		logic [POS_WIDTH-1:0] position;
		logic [2:0]           nres;
		logic [3:0][7:0]      bytes;
	} srp_cmd_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
	endfunction

	function automatic logic [3:0] hex_of(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c inside {[8'h30:8'h39]})
			v = c - 8'h30;
		else if (c inside {[8'h41:8'h46]})
			v = c - 8'h37;
		else if (c inside {[8'h61:8'h66]})
			v = c - 8'h57;
		return v[3:0];
	endfunction

endpackage

FILE: design/srp_front.sv
// Parser front end: configuration registers, parse state machine and command build.
// Depends on srp_pkg and string_render_parser_defines.svh.
`include "string_render_parser_defines.svh"

module srp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             cmd_full,
	input  srp_pkg::srp_in_t item,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [7:0]       wr_data,
	output logic             cmd_push,
	output srp_pkg::srp_cmd_t cmd
);
	import srp_pkg::*;

	logic [7:0]           quote_q;
	logic                 big_end_q;
	logic                 bom_q;
	logic [1:0]           cs_ovr_q;

	srp_state_t           st_q, st_d;
	logic [31:0]          acc_q, acc_d;
	logic [3:0]           dig_q, dig_d;
	logic [POS_WIDTH-1:0] cnt_q, cnt_d;
	logic                 failed_q, failed_d;
	logic [POS_WIDTH-1:0] fpos_q, fpos_d;

	logic                 take;
	logic [7:0]           c;
	logic                 c_hex;
	logic [3:0]           c_val;
	logic                 c_quote;
	logic                 ok;
	logic                 start_cs;
	logic [1:0]           prefix_cs;
	logic [1:0]           eff_cs;
	logic [31:0]          acc_sh;
	logic [3:0]           dig_dec;
	logic [2:0]           bom_n;
	logic [3:0][7:0]      bom_b;
	logic [2:0]           dat_n;
	logic [3:0][7:0]      dat_b;

	assign take    = push && !cmd_full;
	assign c       = item.char_code;
	assign c_hex   = is_hex(c);
	assign c_val   = hex_of(c);
	assign c_quote = (c == quote_q) || (c == CH_APOS);
	assign acc_sh  = {acc_q[27:0], c_val};
	assign dig_dec = dig_q - 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q   <= CH_DQUOTE;
			big_end_q <= 1'b0;
			bom_q     <= 1'b0;
			cs_ovr_q  <= CS_PREFIX;
		end else if (wr_en) begin
			case (wr_index)
				REG_QUOTE:   quote_q   <= wr_data;
				REG_BIG_END: big_end_q <= wr_data[0];
				REG_BOM:     bom_q     <= wr_data[0];
				REG_CHARSET: cs_ovr_q  <= wr_data[1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_INIT;
			acc_q    <= '0;
			dig_q    <= '0;
			cnt_q    <= '0;
			failed_q <= 1'b0;
			fpos_q   <= '0;
		end else begin
			st_q     <= st_d;
			acc_q    <= acc_d;
			dig_q    <= dig_d;
			cnt_q    <= cnt_d;
			failed_q <= failed_d;
			fpos_q   <= fpos_d;
		end
	end

	// character acceptance per state
	always_comb begin
		case (st_q)
			ST_INIT:   ok = (c == CH_LOW_U) || (c == CH_UP_U) || c_quote || c_hex;
			ST_PREFIX: ok = (c == CH_EIGHT) || c_quote || c_hex;
			ST_UNIT:   ok = c_quote || c_hex;
			ST_STR:    ok = 1'b1;
			ST_BYTE:   ok = c_hex;
			ST_SUFFIX: ok = (c == CH_LOW_H);
			ST_COMMA:  ok = (c == CH_COMMA);
			ST_ESCAPE: ok = c inside {CH_ZERO, CH_LOW_A, CH_LOW_B, CH_LOW_T, CH_LOW_N,
				CH_LOW_V, CH_LOW_F, CH_LOW_R, CH_BSLASH, CH_DQUOTE, CH_APOS,
				CH_LOW_X, CH_LOW_U, CH_UP_U};
			ST_CODE:   ok = c_hex;
			default:   ok = 1'b0;
		endcase
	end

	// charset choice and byte-order mark
	always_comb begin
		start_cs  = 1'b0;
		prefix_cs = CS_ONE;
		if (st_q == ST_INIT) begin
			start_cs  = (c != CH_LOW_U);
			prefix_cs = (c == CH_UP_U) ? CS_FOUR : CS_ONE;
		end else if (st_q == ST_PREFIX) begin
			start_cs  = 1'b1;
			prefix_cs = (c == CH_EIGHT) ? CS_ONE : CS_TWO;
		end
		eff_cs = (cs_ovr_q != CS_PREFIX) ? cs_ovr_q : prefix_cs;
		bom_n  = 3'd0;
		bom_b  = '0;
		if (start_cs && bom_q) begin
			case (eff_cs)
				CS_TWO: begin
					bom_n = 3'd2;
					bom_b[0] = big_end_q ? BOM_HI : BOM_LO;
					bom_b[1] = big_end_q ? BOM_LO : BOM_HI;
				end
				CS_FOUR: begin
					bom_n = 3'd4;
					bom_b[0] = big_end_q ? 8'h00 : BOM_LO;
					bom_b[1] = big_end_q ? 8'h00 : BOM_HI;
					bom_b[2] = big_end_q ? BOM_HI : 8'h00;
					bom_b[3] = big_end_q ? BOM_LO : 8'h00;
				end
				default: ;
			endcase
		end
	end

	// next state and data bytes
	always_comb begin
		st_d     = st_q;
		acc_d    = acc_q;
		dig_d    = dig_q;
		cnt_d    = cnt_q;
		failed_d = failed_q;
		fpos_d   = fpos_q;
		dat_n    = 3'd0;
		dat_b    = '0;
		cmd_push = 1'b0;
		cmd      = '0;
		if (take) begin
			if (item.action) begin
				cmd_push     = 1'b1;
				cmd.nres     = 3'd1;
				cmd.position = failed_q ? fpos_q : cnt_q;
				cmd.kind     = (!failed_q && (st_q == ST_INIT || st_q == ST_UNIT ||
					st_q == ST_COMMA)) ? KIND_ACCEPT : KIND_REJECT;
				st_d     = ST_INIT;
				acc_d    = '0;
				dig_d    = '0;
				cnt_d    = '0;
				failed_d = 1'b0;
				fpos_d   = '0;
			end else if (!failed_q) begin
				if (!ok) begin
					failed_d     = 1'b1;
					fpos_d       = cnt_q;
					cmd_push     = 1'b1;
					cmd.nres     = 3'd1;
					cmd.kind     = KIND_BADCH;
					cmd.position = cnt_q;
				end else begin
					if (cnt_q != '1)
						cnt_d = cnt_q + 1'b1;
					case (st_q)
						ST_INIT, ST_PREFIX, ST_UNIT: begin
							if (st_q == ST_INIT && c == CH_LOW_U)
								st_d = ST_PREFIX;
							else if ((st_q == ST_INIT && c == CH_UP_U) ||
								(st_q == ST_PREFIX && c == CH_EIGHT))
								st_d = ST_UNIT;
							else if (c_hex) begin
								acc_d = {28'd0, c_val};
								st_d  = ST_BYTE;
							end else if (c_quote)
								st_d = ST_STR;
						end
						ST_STR: begin
							if (c_quote)
								st_d = ST_COMMA;
							else if (c == CH_BSLASH)
								st_d = ST_ESCAPE;
							else begin
								dat_n    = 3'd1;
								dat_b[0] = c;
							end
						end
						ST_BYTE: begin
							acc_d = acc_sh;
							st_d  = ST_SUFFIX;
						end
						ST_SUFFIX: begin
							dat_n    = 3'd1;
							dat_b[0] = acc_q[7:0];
							acc_d    = '0;
							st_d     = ST_COMMA;
						end
						ST_COMMA: st_d = ST_UNIT;
						ST_ESCAPE: begin
							st_d  = ST_STR;
							dat_n = 3'd1;
							case (c)
								CH_ZERO:  dat_b[0] = 8'd0;
								CH_LOW_A: dat_b[0] = 8'd7;
								CH_LOW_B: dat_b[0] = 8'd8;
								CH_LOW_T: dat_b[0] = 8'd9;
								CH_LOW_N: dat_b[0] = 8'd10;
								CH_LOW_V: dat_b[0] = 8'd11;
								CH_LOW_F: dat_b[0] = 8'd12;
								CH_LOW_R: dat_b[0] = 8'd13;
								CH_LOW_X: begin
									dat_n = 3'd0;
									dig_d = 4'd2;
									st_d  = ST_CODE;
								end
								CH_LOW_U: begin
									dat_n = 3'd0;
									dig_d = 4'd4;
									st_d  = ST_CODE;
								end
								CH_UP_U: begin
									dat_n = 3'd0;
									dig_d = 4'd8;
									st_d  = ST_CODE;
								end
								default:  dat_b[0] = c;
							endcase
						end
						ST_CODE: begin
							acc_d = acc_sh;
							dig_d = dig_dec;
							if (dig_dec == 4'd0) begin
								acc_d = '0;
								st_d  = ST_STR;
								// negative or below 0x10000: one byte, else surrogate pair
								if (acc_sh[31] || acc_sh[30:16] == 15'd0) begin
									dat_n    = 3'd1;
									dat_b[0] = acc_sh[7:0];
								end else begin
									dat_n    = 3'd2;
									dat_b[0] = acc_sh[17:10] - SURR_OFS;
									dat_b[1] = acc_sh[7:0];
								end
							end
						end
						default: ;
					endcase
					// a charset start never emits data in the same step
					cmd.kind = KIND_DATA;
					if (bom_n != 3'd0) begin
						cmd.nres  = bom_n;
						cmd.bytes = bom_b;
					end else begin
						cmd.nres  = dat_n;
						cmd.bytes = dat_b;
					end
					cmd_push = (bom_n != 3'd0) || (dat_n != 3'd0);
				end
			end
		end
	end

	`SRP_ASSERT_NXT(a_end_clears, clk, arst_n, take && item.action,
		st_q == ST_INIT && !failed_q && cnt_q == '0)
	`SRP_ASSERT_IMP(a_push_nonempty, clk, arst_n, cmd_push,
		cmd.nres != 3'd0 && cmd.nres <= 3'd4)

endmodule

FILE: design/srp_cmd_fifo.sv
// Short command queue between the parser front end and the result emitter.
// Depends on srp_pkg and string_render_parser_defines.svh.
`include "string_render_parser_defines.svh"

module srp_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  srp_pkg::srp_cmd_t wdata,
	input  logic              pop,
	output srp_pkg::srp_cmd_t head,
	output logic              full,
	output logic              empty
);
	import srp_pkg::*;

	srp_cmd_t             mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	`SRP_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CMD_CNT_W'(CMD_DEPTH))
	`SRP_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !empty)

endmodule

FILE: design/srp_back.sv
// Result emitter: walks each queued command one result per cycle, while results are popped, into the output register.
// Depends on srp_pkg and string_render_parser_defines.svh.
`include "string_render_parser_defines.svh"

module srp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  srp_pkg::srp_cmd_t head,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	input  logic              pop,
	output logic              empty,
	output srp_pkg::srp_out_t result
);
	import srp_pkg::*;

	srp_out_t   res_q;
	logic       res_valid_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_last;

	assign load    = !cmd_empty && (!res_valid_q || pop);
	assign at_last = ({1'b0, idx_q} == head.nres - 3'd1);
	assign cmd_pop = load && at_last;
	assign empty   = !res_valid_q;
	assign result  = res_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_byte <= head.bytes[idx_q];
			res_q.kind     <= head.kind;
			res_q.position <= head.position;
			res_q.last     <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load)
				res_valid_q <= 1'b1;
			else if (pop)
				res_valid_q <= 1'b0;
			if (load)
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	`SRP_ASSERT_IMP(a_status_is_last, clk, arst_n,
		res_valid_q && res_q.kind != KIND_DATA, res_q.last)

endmodule

FILE: design/string_render_parser.sv
// Top level of the string render parser: front end, command queue and result emitter.
// Depends on srp_pkg, srp_front, srp_cmd_fifo and srp_back.
//
// Accepts one rendered-string character (or an end marker) per cycle while full is low,
// on a queue-style push/full input, and returns bytes and status on a queue-style
// empty/pop output. The front end parses each item in the cycle it is accepted and
// queues a command of one to four results; the emitter delivers one result per cycle
// while results are popped. Most items yield one result, a surrogate pair two and a
// byte-order mark up to four. The output port bandwidth of one result per cycle sets
// the sustained rate; a two-entry command queue and the output register let the input
// keep flowing while results wait to be popped. Configuration must be written through
// wr_en/wr_index/wr_data only while the block is idle; the block does not enforce this.
module string_render_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  srp_pkg::srp_in_t  item,
	output logic              empty,
	input  logic              pop,
	output srp_pkg::srp_out_t result,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [7:0]        wr_data
);
	import srp_pkg::*;

	srp_cmd_t cmd;
	srp_cmd_t head;
	logic     cmd_push;
	logic     cmd_pop;
	logic     cmd_empty;

	srp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.cmd_full (full),
		.item     (item),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	srp_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd),
		.pop    (cmd_pop),
		.head   (head),
		.full   (full),
		.empty  (cmd_empty)
	);

	srp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
